[sv/hid_keyboard_report_differ_assert.svh]
// Assertion macros for the key report differ, used by the merge stage module.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef HID_KEYBOARD_REPORT_DIFFER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_DIFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HKRD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HKRD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hkrd_pkg.sv]
// Package for the keyboard report differ: sizes, request codes and shared types.
// No dependencies; used by the interfaces and every module.
package hkrd_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int EVT_COUNT  = 2 * SLOT_COUNT;
    localparam int KEY_W      = 8;
    localparam int EVT_IDX_W  = $clog2(EVT_COUNT);

    localparam logic [7:0] ACCEPTED_LEN = 8'd8;
    localparam logic       REQ_REPORT   = 1'b0;
    localparam logic       REQ_CLEAR    = 1'b1;

    typedef logic [KEY_W-1:0]                  key_t;
    typedef logic [SLOT_COUNT-1:0][KEY_W-1:0]  slots_t;
    typedef logic [EVT_COUNT-1:0]              evt_mask_t;
    typedef logic [EVT_IDX_W-1:0]              evt_idx_t;

    // One report's worth of pending events: releases in bits 0..5, presses above
    typedef struct packed {
        evt_mask_t                          mask;
        logic [EVT_COUNT-1:0][KEY_W-1:0]    codes;
        key_t                               mod;
    } batch_t;

endpackage

[sv/hkrd_if.sv]
// Handshake interfaces for the keyboard report differ: report request in, key event out.
// Depends on hkrd_pkg.
interface hkrd_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [7:0]         report_len;
    hkrd_pkg::key_t     modifier;
    hkrd_pkg::key_t     key0;
    hkrd_pkg::key_t     key1;
    hkrd_pkg::key_t     key2;
    hkrd_pkg::key_t     key3;
    hkrd_pkg::key_t     key4;
    hkrd_pkg::key_t     key5;

    modport source (output valid, req_type, report_len, modifier,
                    key0, key1, key2, key3, key4, key5, input ready);
    modport sink   (input valid, req_type, report_len, modifier,
                    key0, key1, key2, key3, key4, key5, output ready);
endinterface

interface hkrd_evt_if;
    logic               valid;
    logic               ready;
    hkrd_pkg::key_t     keycode;
    hkrd_pkg::key_t     mod_bits;
    logic               pressed;
    logic               last;

    modport source (output valid, keycode, mod_bits, pressed, last, input ready);
    modport sink   (input valid, keycode, mod_bits, pressed, last, output ready);
endinterface

[sv/hkrd_lane.sv]
// One compare lane: flags a nonzero key code that is absent from a set of six slots.
// Depends on hkrd_pkg.
module hkrd_lane (
    input  hkrd_pkg::key_t   code,
    input  hkrd_pkg::slots_t slots,
    output logic             hit
);
    import hkrd_pkg::*;

    logic [SLOT_COUNT-1:0] match;

    // Compare the code against every slot at once
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match[i] = (slots[i] == code);
        end
    end

    assign hit = (code != '0) && (match == '0);

endmodule

[sv/hkrd_merge.sv]
// Merge stage: holds the lane results of one report and sends them out one event a cycle while the receiver is ready.
// Depends on hkrd_pkg, hkrd_evt_if and the assertion macro header.
`include "hid_keyboard_report_differ_assert.svh"

module hkrd_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  hkrd_pkg::batch_t   batch_in,
    output logic               can_load,
    hkrd_evt_if.source         evt
);
    import hkrd_pkg::*;

    logic      batch_valid_reg, batch_valid_next;
    evt_mask_t mask_reg, mask_next;
    logic [EVT_COUNT-1:0][KEY_W-1:0] codes_reg, codes_next;
    key_t      mod_reg, mod_next;

    logic      out_valid_reg, out_valid_next;
    key_t      out_code_reg, out_code_next;
    key_t      out_mod_reg, out_mod_next;
    logic      out_pressed_reg, out_pressed_next;
    logic      out_last_reg, out_last_next;

    evt_idx_t  idx;
    evt_mask_t mask_rest;
    logic      is_last;
    logic      pop;

    // Find the lowest pending event: releases come before presses
    always_comb
    begin
        idx = '0;
        for (int i = EVT_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = EVT_IDX_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & ~(EVT_COUNT'(1) << idx);
    assign is_last   = (mask_rest == '0);
    assign pop       = batch_valid_reg && (!out_valid_reg || evt.ready);
    assign can_load  = !batch_valid_reg || (pop && is_last);

    // Load a new batch or retire the event being sent
    always_comb
    begin
        batch_valid_next = batch_valid_reg;
        mask_next        = mask_reg;
        codes_next       = codes_reg;
        mod_next         = mod_reg;
        if (load)
        begin
            batch_valid_next = 1'b1;
            mask_next        = batch_in.mask;
            codes_next       = batch_in.codes;
            mod_next         = batch_in.mod;
        end
        else if (pop)
        begin
            batch_valid_next = !is_last;
            mask_next        = mask_rest;
        end
    end

    // Fill the output register, drop it once taken
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_code_next    = out_code_reg;
        out_mod_next     = out_mod_reg;
        out_pressed_next = out_pressed_reg;
        out_last_next    = out_last_reg;
        if (pop)
        begin
            out_valid_next   = 1'b1;
            out_code_next    = codes_reg[idx];
            out_mod_next     = mod_reg;
            out_pressed_next = (idx >= EVT_IDX_W'(SLOT_COUNT));
            out_last_next    = is_last;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_valid_reg <= 1'b0;
            mask_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            batch_valid_reg <= batch_valid_next;
            mask_reg        <= mask_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg       <= codes_next;
        mod_reg         <= mod_next;
        out_code_reg    <= out_code_next;
        out_mod_reg     <= out_mod_next;
        out_pressed_reg <= out_pressed_next;
        out_last_reg    <= out_last_next;
    end

    assign evt.valid    = out_valid_reg;
    assign evt.keycode  = out_code_reg;
    assign evt.mod_bits = out_mod_reg;
    assign evt.pressed  = out_pressed_reg;
    assign evt.last     = out_last_reg;

    `HKRD_ASSERT_IMP(a_batch_nonempty, batch_valid_reg, mask_reg != '0, "held batch has no events")
    `HKRD_ASSERT_IMP(a_load_only_free, load, can_load, "batch loaded while still busy")
    `HKRD_ASSERT_NEXT(a_hold_stalled, batch_valid_reg && !pop, $stable(mask_reg), "stalled batch changed")
    `HKRD_ASSERT_NEXT(a_pop_fills_out, pop, out_valid_reg, "popped event not presented")
    `HKRD_ASSERT_NEXT(a_last_marked, pop && is_last, out_last_reg, "final event of a report not marked")

endmodule

[sv/hid_keyboard_report_differ.sv]
// Top level of the keyboard report differ: six release lanes, six press lanes, merge stage.
// Depends on hkrd_pkg, hkrd_if, hkrd_lane and hkrd_merge.
//
// req channel: one request per handshake. A clear request zeroes the stored key
// slots and emits nothing; a keyboard report with length 8 is compared with the
// stored slots in twelve compare lanes, each a six-way equality check, in the
// cycle it is accepted, and then becomes the stored report. Other lengths are dropped.
// evt channel: one key event per handshake, releases in slot order first, then
// presses in slot order, each with the report's modifier; last marks the final one.
// The first event of a report is held in the merge stage, then in the output register.
// Throughput: one event per cycle from the merge stage while the receiver is ready;
// the next request is taken in the cycle the last event of a report moves to the
// output register, so reports stream back to back. A report that yields no event,
// a clear, or a dropped report does not occupy the merge stage.
// Reset clears the stored slots and empties the merge stage and output register.
// When the receiver stalls, the output register holds its event, the merge stage
// holds the rest, and req.ready falls until the pending events can drain.
module hid_keyboard_report_differ (
    input  logic       clk,
    input  logic       rst_n,
    hkrd_req_if.sink   req,
    hkrd_evt_if.source evt
);
    import hkrd_pkg::*;

    slots_t    prev_reg, prev_next;
    slots_t    now;
    evt_mask_t hits;
    batch_t    batch;
    logic      accept;
    logic      is_report;
    logic      can_load;
    logic      load;

    assign now = {req.key5, req.key4, req.key3, req.key2, req.key1, req.key0};

    // Release lanes check old slots against the new report, press lanes the reverse
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_lane
        hkrd_lane u_rel (
            .code  (prev_reg[i]),
            .slots (now),
            .hit   (hits[i])
        );
        hkrd_lane u_prs (
            .code  (now[i]),
            .slots (prev_reg),
            .hit   (hits[SLOT_COUNT + i])
        );
    end

    assign batch.mask  = hits;
    assign batch.codes = {now, prev_reg};
    assign batch.mod   = req.modifier;

    assign req.ready = can_load;
    assign accept    = req.valid && can_load;
    assign is_report = (req.req_type == REQ_REPORT) && (req.report_len == ACCEPTED_LEN);
    assign load      = accept && is_report && (hits != '0);

    // Update the stored slots on a clear or an accepted report
    always_comb
    begin
        prev_next = prev_reg;
        if (accept)
        begin
            if (req.req_type == REQ_CLEAR)
            begin
                prev_next = '0;
            end
            else if (is_report)
            begin
                prev_next = now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    hkrd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch_in (batch),
        .can_load (can_load),
        .evt      (evt)
    );

endmodule
